// ===== design/socg_pkg.sv =====
// ----------------------------------------------------------------------------
// socg_pkg: shared types and constants for the sphere claim grid
// Field widths, register indexes, reset values and the map control group.
// ----------------------------------------------------------------------------
`default_nettype none

package socg_pkg;

    localparam int GRID_SIZE_DEF  = 64;
    localparam int MAX_RADIUS_DEF = 15;

    localparam int COORD_W    = 6;
    localparam int DENS_W     = 32;
    localparam int RADIUS_W   = 4;
    localparam int LIMIT_W    = 10;
    localparam int COUNT_W    = 19;
    localparam int CFG_IDX_W  = 2;
    localparam int CFG_DATA_W = 32;

    localparam logic [COUNT_W-1:0] COUNT_MAX = {COUNT_W{1'b1}};

    // configuration register indexes
    localparam logic [CFG_IDX_W-1:0] CFG_THRESHOLD = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_RADIUS    = 2'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_LIMIT_SQ  = 2'd2;

    localparam logic signed [DENS_W-1:0] THRESHOLD_RST = 32'sd65536;
    localparam logic [RADIUS_W-1:0]      RADIUS_RST    = 4'd1;
    localparam logic [LIMIT_W-1:0]       LIMIT_SQ_RST  = 10'd1;

    // command codes
    localparam logic CMD_TEST  = 1'b0;
    localparam logic CMD_CLEAR = 1'b1;

    typedef struct packed {
        logic rd_en;
        logic wr_en;
    } t_map_ctl;

endpackage

`default_nettype wire

// ===== design/socg_map.sv =====
// ----------------------------------------------------------------------------
// socg_map: occupancy map storage
// One row per (x, y) pair, one bit per z. One write and one registered read
// port per cycle.
// ----------------------------------------------------------------------------
`default_nettype none

module socg_map #(
    parameter int GRID = socg_pkg::GRID_SIZE_DEF
) (
    input  logic                          i_clk,
    input  socg_pkg::t_map_ctl            i_ctl,
    input  logic [2*$clog2(GRID)-1:0]     i_rd_addr,
    input  logic [2*$clog2(GRID)-1:0]     i_wr_addr,
    input  logic [GRID-1:0]               i_wr_data,
    output logic [GRID-1:0]               o_rd_data
);
    import socg_pkg::*;

    localparam int AW   = 2 * $clog2(GRID);
    localparam int ROWS = 1 << AW;

    logic [GRID-1:0] r_map [ROWS];
    logic [GRID-1:0] r_rd_data;

    always_ff @(posedge i_clk) begin
        if (i_ctl.wr_en) begin
            r_map[i_wr_addr] <= i_wr_data;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_ctl.rd_en) begin
            r_rd_data <= r_map[i_rd_addr];
        end
    end

    assign o_rd_data = r_rd_data;

endmodule

`default_nettype wire

// ===== design/socg_dist.sv =====
// ----------------------------------------------------------------------------
// socg_dist: sphere membership unit
// Squares the three offsets, sums them and compares against the limit.
// ----------------------------------------------------------------------------
`default_nettype none

module socg_dist #(
    parameter int MAX_RADIUS = socg_pkg::MAX_RADIUS_DEF
) (
    input  logic signed [$clog2(MAX_RADIUS+1):0] i_dx,
    input  logic signed [$clog2(MAX_RADIUS+1):0] i_dy,
    input  logic signed [$clog2(MAX_RADIUS+1):0] i_dz,
    input  logic [socg_pkg::LIMIT_W-1:0]         i_limit,
    output logic                                 o_inside
);
    import socg_pkg::*;

    localparam int RW   = $clog2(MAX_RADIUS + 1);
    localparam int OW   = RW + 1;
    localparam int SQW  = 2 * OW;
    localparam int SUMW = SQW + 2;
    localparam int CMPW = (SUMW > LIMIT_W) ? SUMW : LIMIT_W;

    logic [OW-1:0]   neg_x, neg_y, neg_z;
    logic [SQW-1:0]  mag_x, mag_y, mag_z;
    logic [SQW-1:0]  sq_x, sq_y, sq_z;
    logic [SUMW-1:0] sum;

    always_comb begin
        neg_x = -i_dx;
        neg_y = -i_dy;
        neg_z = -i_dz;
        mag_x = SQW'(i_dx[OW-1] ? neg_x[RW-1:0] : i_dx[RW-1:0]);
        mag_y = SQW'(i_dy[OW-1] ? neg_y[RW-1:0] : i_dy[RW-1:0]);
        mag_z = SQW'(i_dz[OW-1] ? neg_z[RW-1:0] : i_dz[RW-1:0]);
        sq_x  = mag_x * mag_x;
        sq_y  = mag_y * mag_y;
        sq_z  = mag_z * mag_z;
        sum   = SUMW'(sq_x) + SUMW'(sq_y) + SUMW'(sq_z);
        o_inside = CMPW'(sum) <= CMPW'(i_limit);
    end

endmodule

`default_nettype wire

// ===== design/socg_seq.sv =====
// ----------------------------------------------------------------------------
// socg_seq: walk sequencer
// Steps the sphere offsets row by row, builds a z mask per row, then either
// tests the row against the map or merges the mask into it. Also runs the
// map clearing sweep and drives the result strobe.
// ----------------------------------------------------------------------------
`default_nettype none

module socg_seq #(
    parameter int GRID       = socg_pkg::GRID_SIZE_DEF,
    parameter int MAX_RADIUS = socg_pkg::MAX_RADIUS_DEF
) (
    input  logic                               i_clk,
    input  logic                               i_rst_n,
    input  logic                               start,
    output logic                               busy,
    input  logic                               i_cmd,
    input  logic [socg_pkg::COORD_W-1:0]       i_cell_x,
    input  logic [socg_pkg::COORD_W-1:0]       i_cell_y,
    input  logic [socg_pkg::COORD_W-1:0]       i_cell_z,
    input  logic signed [socg_pkg::DENS_W-1:0] i_density,
    input  logic signed [socg_pkg::DENS_W-1:0] i_threshold,
    input  logic [socg_pkg::RADIUS_W-1:0]      i_radius,
    input  logic [socg_pkg::LIMIT_W-1:0]       i_limit,
    output socg_pkg::t_map_ctl                 o_map_ctl,
    output logic [2*$clog2(GRID)-1:0]          o_rd_addr,
    output logic [2*$clog2(GRID)-1:0]          o_wr_addr,
    output logic [GRID-1:0]                    o_wr_data,
    input  logic [GRID-1:0]                    i_rd_data,
    output logic                               o_result_valid,
    output logic                               o_halo_found,
    output logic [socg_pkg::COORD_W-1:0]       o_halo_x,
    output logic [socg_pkg::COORD_W-1:0]       o_halo_y,
    output logic [socg_pkg::COORD_W-1:0]       o_halo_z,
    output logic [socg_pkg::COUNT_W-1:0]       o_halos_since_clear
);
    import socg_pkg::*;

    localparam int CW = $clog2(GRID);
    localparam int AW = 2 * CW;
    localparam int RW = $clog2(MAX_RADIUS + 1);
    localparam int OW = RW + 1;

    typedef enum logic [7:0] {
        S_CLEAR = 8'b0000_0001,
        S_IDLE  = 8'b0000_0010,
        S_NORM  = 8'b0000_0100,
        S_PREP  = 8'b0000_1000,
        S_SWEEP = 8'b0001_0000,
        S_READ  = 8'b0010_0000,
        S_TEST  = 8'b0100_0000,
        S_DONE  = 8'b1000_0000
    } t_state;

    function automatic logic [CW-1:0] f_inc(input logic [CW-1:0] c);
        return (c == CW'(GRID - 1)) ? '0 : c + CW'(1);
    endfunction

    function automatic logic [CW-1:0] f_dec(input logic [CW-1:0] c);
        return (c == '0) ? CW'(GRID - 1) : c - CW'(1);
    endfunction

    t_state                r_state, n_state;
    logic [AW-1:0]         r_row, n_row;
    logic                  r_reply, n_reply;
    logic [COUNT_W-1:0]    r_count, n_count;
    logic [COORD_W-1:0]    r_nx, n_nx, r_ny, n_ny, r_nz, n_nz;
    logic [CW-1:0]         r_sx, n_sx, r_sy, n_sy, r_sz, n_sz;
    logic [CW-1:0]         r_wx, n_wx, r_wy, n_wy, r_wz, n_wz;
    logic signed [OW-1:0]  r_dx, n_dx, r_dy, n_dy, r_dz, n_dz;
    logic [RW-1:0]         r_k, n_k;
    logic [RW-1:0]         r_r, n_r;
    logic [GRID-1:0]       r_mask, n_mask;
    logic                  r_mark, n_mark;
    logic                  r_found, n_found;
    logic                  r_out_valid, n_out_valid;
    logic                  r_out_found, n_out_found;
    logic [COORD_W-1:0]    r_out_x, n_out_x, r_out_y, n_out_y, r_out_z, n_out_z;

    logic signed [OW-1:0]  pos_r, neg_r;
    logic [GRID-1:0]       wz_bit;
    logic                  in_sphere;
    logic [RW-1:0]         radius_eff;
    logic                  nx_hi, ny_hi, nz_hi;

    socg_dist #(
        .MAX_RADIUS (MAX_RADIUS)
    ) u_dist (
        .i_dx     (r_dx),
        .i_dy     (r_dy),
        .i_dz     (r_dz),
        .i_limit  (i_limit),
        .o_inside (in_sphere)
    );

    assign pos_r  = {1'b0, r_r};
    assign neg_r  = -pos_r;
    assign wz_bit = {{(GRID-1){1'b0}}, 1'b1} << r_wz;
    assign radius_eff = (int'(i_radius) > MAX_RADIUS) ? RW'(MAX_RADIUS) : RW'(i_radius);
    assign nx_hi  = int'(r_nx) >= GRID;
    assign ny_hi  = int'(r_ny) >= GRID;
    assign nz_hi  = int'(r_nz) >= GRID;

    always_comb begin
        n_state     = r_state;
        n_row       = r_row;
        n_reply     = r_reply;
        n_count     = r_count;
        n_nx        = r_nx;
        n_ny        = r_ny;
        n_nz        = r_nz;
        n_sx        = r_sx;
        n_sy        = r_sy;
        n_sz        = r_sz;
        n_wx        = r_wx;
        n_wy        = r_wy;
        n_wz        = r_wz;
        n_dx        = r_dx;
        n_dy        = r_dy;
        n_dz        = r_dz;
        n_k         = r_k;
        n_r         = r_r;
        n_mask      = r_mask;
        n_mark      = r_mark;
        n_found     = r_found;
        n_out_valid = 1'b0;
        n_out_found = r_out_found;
        n_out_x     = r_out_x;
        n_out_y     = r_out_y;
        n_out_z     = r_out_z;

        case (r_state)
            S_CLEAR: begin
                n_row = r_row + AW'(1);
                if (r_row == {AW{1'b1}}) begin
                    n_reply = 1'b0;
                    n_found = 1'b0;
                    n_state = r_reply ? S_DONE : S_IDLE;
                end
            end
            S_IDLE: begin
                if (start) begin
                    n_nx    = i_cell_x;
                    n_ny    = i_cell_y;
                    n_nz    = i_cell_z;
                    n_r     = radius_eff;
                    n_mark  = 1'b0;
                    n_found = 1'b0;
                    if (i_cmd == CMD_CLEAR) begin
                        n_row   = '0;
                        n_count = '0;
                        n_reply = 1'b1;
                        n_state = S_CLEAR;
                    end else if (i_density > i_threshold) begin
                        n_state = S_NORM;
                    end else begin
                        n_state = S_DONE;
                    end
                end
            end
            S_NORM: begin
                // fold the centre into the grid
                if (nx_hi) n_nx = r_nx - COORD_W'(GRID);
                if (ny_hi) n_ny = r_ny - COORD_W'(GRID);
                if (nz_hi) n_nz = r_nz - COORD_W'(GRID);
                if (!nx_hi && !ny_hi && !nz_hi) begin
                    n_sx    = CW'(r_nx);
                    n_sy    = CW'(r_ny);
                    n_sz    = CW'(r_nz);
                    n_k     = r_r;
                    n_state = S_PREP;
                end
            end
            S_PREP: begin
                // step the corner back by the radius, wrapping each axis
                if (r_k == '0) begin
                    n_dx    = neg_r;
                    n_dy    = neg_r;
                    n_dz    = neg_r;
                    n_wx    = r_sx;
                    n_wy    = r_sy;
                    n_wz    = r_sz;
                    n_mask  = '0;
                    n_state = S_SWEEP;
                end else begin
                    n_sx = f_dec(r_sx);
                    n_sy = f_dec(r_sy);
                    n_sz = f_dec(r_sz);
                    n_k  = r_k - RW'(1);
                end
            end
            S_SWEEP: begin
                if (in_sphere) begin
                    n_mask = r_mask | wz_bit;
                end
                if (r_dz == pos_r) begin
                    n_state = S_READ;
                end else begin
                    n_dz = r_dz + OW'(1);
                    n_wz = f_inc(r_wz);
                end
            end
            S_READ: begin
                n_state = S_TEST;
            end
            S_TEST: begin
                if (!r_mark && ((i_rd_data & r_mask) != '0)) begin
                    n_found = 1'b0;
                    n_state = S_DONE;
                end else begin
                    n_dz    = neg_r;
                    n_wz    = r_sz;
                    n_mask  = '0;
                    n_state = S_SWEEP;
                    if (r_dy == pos_r) begin
                        n_dy = neg_r;
                        n_wy = r_sy;
                        if (r_dx == pos_r) begin
                            // pass complete: start marking, or finish the claim
                            n_dx = neg_r;
                            n_wx = r_sx;
                            if (!r_mark) begin
                                n_mark = 1'b1;
                            end else begin
                                if (r_count != COUNT_MAX) begin
                                    n_count = r_count + COUNT_W'(1);
                                end
                                n_found = 1'b1;
                                n_state = S_DONE;
                            end
                        end else begin
                            n_dx = r_dx + OW'(1);
                            n_wx = f_inc(r_wx);
                        end
                    end else begin
                        n_dy = r_dy + OW'(1);
                        n_wy = f_inc(r_wy);
                    end
                end
            end
            S_DONE: begin
                n_out_valid = 1'b1;
                n_out_found = r_found;
                n_out_x     = r_found ? r_nx : '0;
                n_out_y     = r_found ? r_ny : '0;
                n_out_z     = r_found ? r_nz : '0;
                n_state     = S_IDLE;
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_CLEAR;
            r_row       <= '0;
            r_reply     <= 1'b0;
            r_count     <= '0;
            r_mark      <= 1'b0;
            r_found     <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_row       <= n_row;
            r_reply     <= n_reply;
            r_count     <= n_count;
            r_mark      <= n_mark;
            r_found     <= n_found;
            r_out_valid <= n_out_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_nx        <= n_nx;
        r_ny        <= n_ny;
        r_nz        <= n_nz;
        r_sx        <= n_sx;
        r_sy        <= n_sy;
        r_sz        <= n_sz;
        r_wx        <= n_wx;
        r_wy        <= n_wy;
        r_wz        <= n_wz;
        r_dx        <= n_dx;
        r_dy        <= n_dy;
        r_dz        <= n_dz;
        r_k         <= n_k;
        r_r         <= n_r;
        r_mask      <= n_mask;
        r_out_found <= n_out_found;
        r_out_x     <= n_out_x;
        r_out_y     <= n_out_y;
        r_out_z     <= n_out_z;
    end

    assign busy = (r_state != S_IDLE);

    always_comb begin
        o_map_ctl.rd_en = (r_state == S_READ);
        o_map_ctl.wr_en = (r_state == S_CLEAR) || ((r_state == S_TEST) && r_mark);
    end

    assign o_rd_addr = {r_wx, r_wy};
    assign o_wr_addr = (r_state == S_CLEAR) ? r_row : {r_wx, r_wy};
    assign o_wr_data = (r_state == S_CLEAR) ? '0 : (i_rd_data | r_mask);

    assign o_result_valid      = r_out_valid;
    assign o_halo_found        = r_out_found;
    assign o_halo_x            = r_out_x;
    assign o_halo_y            = r_out_y;
    assign o_halo_z            = r_out_z;
    assign o_halos_since_clear = r_count;

    a_strobe_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_result_valid |-> !busy)
        else $error("result strobe while busy");

    a_accept_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (start && !busy) |=> busy)
        else $error("accepted beat did not raise busy");

    a_found_count: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_result_valid && o_halo_found) |-> (o_halos_since_clear != '0))
        else $error("claimed halo with zero count");

    a_miss_coords: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_result_valid && !o_halo_found) |->
            (o_halo_x == '0 && o_halo_y == '0 && o_halo_z == '0))
        else $error("nonzero centre on a miss");

    a_centre_grid: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_result_valid && o_halo_found) |->
            (int'(o_halo_x) < GRID && int'(o_halo_y) < GRID && int'(o_halo_z) < GRID))
        else $error("claimed centre outside the grid");

endmodule

`default_nettype wire

// ===== design/sphere_overlap_claim_grid.sv =====
// A test beat at or below threshold goes from idle straight to the done state and returns
// a miss. A claim with effective radius r (n = 2r+1) walks the n*n (x, y) rows of its sphere
// twice, a check walk and then a mark walk; an overlap ends the check walk early, and the
// centre needs no folding for grids of 64 or more. One beat at a time: each (x, y) row sweeps
// its n z offsets into a mask, then reads its map row and tests it or writes it back merged.
// A clear beat zeroes every map row, resets the halo count and returns a miss. Results cannot
// be stalled. Reset (synchronous, active low) starts a clearing pass; busy stays high.
// ----------------------------------------------------------------------------
// sphere_overlap_claim_grid: periodic sphere claim occupancy grid
// Tests a candidate centre against a one-bit map over a wrapped cubic grid and marks the
// whole sphere when it is free, or zeroes the map on a clear. Results are one-cycle strobes.
// ----------------------------------------------------------------------------
`default_nettype none

module sphere_overlap_claim_grid #(
    parameter int GRID_SIZE  = socg_pkg::GRID_SIZE_DEF,
    parameter int MAX_RADIUS = socg_pkg::MAX_RADIUS_DEF
) (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    input  logic                                start,
    output logic                                busy,
    input  logic                                i_cmd,
    input  logic [socg_pkg::COORD_W-1:0]        i_cell_x,
    input  logic [socg_pkg::COORD_W-1:0]        i_cell_y,
    input  logic [socg_pkg::COORD_W-1:0]        i_cell_z,
    input  logic signed [socg_pkg::DENS_W-1:0]  i_density,
    input  logic                                i_cfg_valid,
    output logic                                o_cfg_ready,
    input  logic [socg_pkg::CFG_IDX_W-1:0]      i_cfg_index,
    input  logic [socg_pkg::CFG_DATA_W-1:0]     i_cfg_data,
    output logic                                o_result_valid,
    output logic                                o_halo_found,
    output logic [socg_pkg::COORD_W-1:0]        o_halo_x,
    output logic [socg_pkg::COORD_W-1:0]        o_halo_y,
    output logic [socg_pkg::COORD_W-1:0]        o_halo_z,
    output logic [socg_pkg::COUNT_W-1:0]        o_halos_since_clear
);
    import socg_pkg::*;

    localparam int AW = 2 * $clog2(GRID_SIZE);

    logic signed [DENS_W-1:0] r_threshold;
    logic [RADIUS_W-1:0]      r_radius;
    logic [LIMIT_W-1:0]       r_limit;

    t_map_ctl                 map_ctl;
    logic [AW-1:0]            rd_addr;
    logic [AW-1:0]            wr_addr;
    logic [GRID_SIZE-1:0]     wr_data;
    logic [GRID_SIZE-1:0]     rd_data;

    assign o_cfg_ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_threshold <= THRESHOLD_RST;
            r_radius    <= RADIUS_RST;
            r_limit     <= LIMIT_SQ_RST;
        end else if (i_cfg_valid && o_cfg_ready) begin
            case (i_cfg_index)
                CFG_THRESHOLD: r_threshold <= $signed(i_cfg_data[DENS_W-1:0]);
                CFG_RADIUS:    r_radius    <= i_cfg_data[RADIUS_W-1:0];
                CFG_LIMIT_SQ:  r_limit     <= i_cfg_data[LIMIT_W-1:0];
                default: begin
                    // drop writes beyond the register list
                end
            endcase
        end
    end

    socg_seq #(
        .GRID       (GRID_SIZE),
        .MAX_RADIUS (MAX_RADIUS)
    ) u_seq (
        .i_clk               (i_clk),
        .i_rst_n             (i_rst_n),
        .start               (start),
        .busy                (busy),
        .i_cmd               (i_cmd),
        .i_cell_x            (i_cell_x),
        .i_cell_y            (i_cell_y),
        .i_cell_z            (i_cell_z),
        .i_density           (i_density),
        .i_threshold         (r_threshold),
        .i_radius            (r_radius),
        .i_limit             (r_limit),
        .o_map_ctl           (map_ctl),
        .o_rd_addr           (rd_addr),
        .o_wr_addr           (wr_addr),
        .o_wr_data           (wr_data),
        .i_rd_data           (rd_data),
        .o_result_valid      (o_result_valid),
        .o_halo_found        (o_halo_found),
        .o_halo_x            (o_halo_x),
        .o_halo_y            (o_halo_y),
        .o_halo_z            (o_halo_z),
        .o_halos_since_clear (o_halos_since_clear)
    );

    socg_map #(
        .GRID (GRID_SIZE)
    ) u_map (
        .i_clk     (i_clk),
        .i_ctl     (map_ctl),
        .i_rd_addr (rd_addr),
        .i_wr_addr (wr_addr),
        .i_wr_data (wr_data),
        .o_rd_data (rd_data)
    );

endmodule

`default_nettype wire
